/* rtl/plni_pkg.sv */
// Shared constants and types for the periodic lattice neighbor index block.
// No dependencies; imported by periodic_lattice_neighbor_index.
`timescale 1ns / 1ps

package plni_pkg;

	localparam int MAX_DIMS      = 4;
	localparam int MAX_SIDE      = 64;
	localparam int IDX_W         = 24;                   // site index width
	localparam int VOL_W         = IDX_W + 1;            // volume reaches 2**24
	localparam int CFG_W         = 32;
	localparam int ADDR_W        = 5;
	localparam int DIMS_W        = 3;                    // dims_used register width
	localparam int LEN_W         = 7;                    // side_len register width
	localparam int COORD_W       = $clog2(MAX_SIDE);     // coordinate 0..MAX_SIDE-1
	localparam int DIV_DIMS      = MAX_DIMS - 1;         // last coordinate needs no divide
	localparam int STEPS_PER_STG = 8;
	localparam int STG_PER_DIM   = IDX_W / STEPS_PER_STG;
	localparam int DIV_STAGES    = DIV_DIMS * STG_PER_DIM;
	localparam int LATENCY       = DIV_STAGES + 2;       // accept edge to strobe sample
	localparam int SETTLE_CYC    = 6;
	localparam int SETTLE_W      = 3;

	typedef logic [LEN_W-1:0] len_t;

	typedef enum logic [DIMS_W-1:0] {
		REG_DIMS_USED  = 3'd0,
		REG_SIDE_LEN_0 = 3'd1,
		REG_SIDE_LEN_1 = 3'd2,
		REG_SIDE_LEN_2 = 3'd3,
		REG_SIDE_LEN_3 = 3'd4
	} reg_idx_t;

	// Payload carried down the radix division pipeline.
	typedef struct packed {
		logic                                in_range;
		logic [IDX_W-1:0]                    idx;
		logic [IDX_W-1:0]                    quo;    // dividend bits in, quotient bits out
		logic [COORD_W-1:0]                  rem;    // partial remainder
		logic [DIV_DIMS-2:0][COORD_W-1:0]    coord;  // finished coordinates
	} div_pl_t;

endpackage

/* rtl/periodic_lattice_neighbor_index.sv */
// Periodic hypercubic lattice neighbor index unit, top level.
// Depends on plni_pkg (constants, register codes, pipeline payload type).
`timescale 1ns / 1ps

// A site index is taken at every rising edge where start is high and busy is
// low, one per cycle with no gaps required. Its result appears on the result
// ports marked by a one-cycle done strobe, in the order the indices were
// taken. The receiver cannot stall the block, so results must be captured in
// the cycle done is high. The pipeline follows the mixed-radix split: three
// 24-bit restoring divisions by the side lengths, eight quotient bits per
// pipeline stage, nine stages in all, plus an entry stage (volume check) and
// an exit stage (neighbor adds). busy is high after reset and after every
// register write while the per-dimension lengths, strides and volume are
// recomputed; it is low at all other times. Registers sit on an APB-style
// port at byte addresses 0 (dims_used) and 4, 8, 12, 16 (side_len_0..3);
// writes are meant to happen with no transaction in flight. Out-of-range
// indices (at or above the volume) give an all-zero result; directions
// beyond dims_used (clamped to 1..4) give zero.
module periodic_lattice_neighbor_index (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [plni_pkg::ADDR_W-1:0] paddr,
	input  logic [plni_pkg::CFG_W-1:0]  pwdata,
	output logic [plni_pkg::CFG_W-1:0]  prdata,
	output logic                        pready,
	// command side
	input  logic                        start,
	output logic                        busy,
	input  logic [plni_pkg::IDX_W-1:0]  site_index,
	// result side
	output logic                        done,
	output logic                        in_range,
	output logic                        parity,
	output logic [plni_pkg::IDX_W-1:0]  fwd_nbr_0,
	output logic [plni_pkg::IDX_W-1:0]  bwd_nbr_0,
	output logic [plni_pkg::IDX_W-1:0]  fwd_nbr_1,
	output logic [plni_pkg::IDX_W-1:0]  bwd_nbr_1,
	output logic [plni_pkg::IDX_W-1:0]  fwd_nbr_2,
	output logic [plni_pkg::IDX_W-1:0]  bwd_nbr_2,
	output logic [plni_pkg::IDX_W-1:0]  fwd_nbr_3,
	output logic [plni_pkg::IDX_W-1:0]  bwd_nbr_3
);
	import plni_pkg::*;

	// Eight restoring-division steps; remainder stays below the divisor.
	function automatic div_pl_t div_steps(input div_pl_t d_in, input len_t len);
		div_pl_t          d;
		logic [COORD_W:0] r;
		d = d_in;
		for (int j = 0; j < STEPS_PER_STG; j++) begin
			r     = {d.rem, d.quo[IDX_W-1]};
			d.quo = {d.quo[IDX_W-2:0], 1'b0};
			if (r >= len) begin
				r        = r - len;
				d.quo[0] = 1'b1;
			end
			d.rem = r[COORD_W-1:0];
		end
		return d;
	endfunction

	//------------------------------------------------------------------
	// Configuration registers
	//------------------------------------------------------------------
	logic                        cfg_wr;
	reg_idx_t                    cfg_idx;
	logic [DIMS_W-1:0]           dims_used_q;
	len_t [MAX_DIMS-1:0]         side_len_q;
	logic [SETTLE_W-1:0]         settle_q;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_used_q <= DIMS_W'(MAX_DIMS);
			for (int d = 0; d < MAX_DIMS; d++) side_len_q[d] <= LEN_W'(8);
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_DIMS_USED:  dims_used_q   <= pwdata[DIMS_W-1:0];
				REG_SIDE_LEN_0: side_len_q[0] <= pwdata[LEN_W-1:0];
				REG_SIDE_LEN_1: side_len_q[1] <= pwdata[LEN_W-1:0];
				REG_SIDE_LEN_2: side_len_q[2] <= pwdata[LEN_W-1:0];
				REG_SIDE_LEN_3: side_len_q[3] <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_DIMS_USED:  prdata = CFG_W'(dims_used_q);
			REG_SIDE_LEN_0: prdata = CFG_W'(side_len_q[0]);
			REG_SIDE_LEN_1: prdata = CFG_W'(side_len_q[1]);
			REG_SIDE_LEN_2: prdata = CFG_W'(side_len_q[2]);
			REG_SIDE_LEN_3: prdata = CFG_W'(side_len_q[3]);
			default:        prdata = '0;
		endcase
	end

	// Hold off commands while derived geometry catches up with the registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= SETTLE_W'(SETTLE_CYC);
		end else if (cfg_wr) begin
			settle_q <= SETTLE_W'(SETTLE_CYC);
		end else if (settle_q != '0) begin
			settle_q <= settle_q - SETTLE_W'(1);
		end
	end

	assign busy = (settle_q != '0);

	//------------------------------------------------------------------
	// Derived geometry: clamped lengths, strides, volume, wrap offsets.
	// At most one multiply per register level.
	//------------------------------------------------------------------
	logic [DIMS_W-1:0]           nd_eff;
	len_t [MAX_DIMS-1:0]         len_eff;
	logic [DIMS_W-1:0]           nd_q;
	len_t [MAX_DIMS-1:0]         len_q;
	logic [IDX_W-1:0]            str2_q;
	logic [IDX_W-1:0]            str3_q;
	logic [VOL_W-1:0]            vol_q;
	logic [MAX_DIMS-1:0][IDX_W-1:0] stride;
	logic [MAX_DIMS-1:0][IDX_W-1:0] stride_nxt;
	logic [MAX_DIMS-1:0][IDX_W-1:0] wrap_q;   // (len-1)*stride

	always_comb begin
		if (dims_used_q == '0)                      nd_eff = DIMS_W'(1);
		else if (dims_used_q > DIMS_W'(MAX_DIMS))   nd_eff = DIMS_W'(MAX_DIMS);
		else                                        nd_eff = dims_used_q;
		for (int d = 0; d < MAX_DIMS; d++) begin
			if (DIMS_W'(d) >= nd_eff)                 len_eff[d] = LEN_W'(1);
			else if (side_len_q[d] == '0)             len_eff[d] = LEN_W'(1);
			else if (side_len_q[d] > LEN_W'(MAX_SIDE)) len_eff[d] = LEN_W'(MAX_SIDE);
			else                                      len_eff[d] = side_len_q[d];
		end
	end

	assign stride[0]     = IDX_W'(1);
	assign stride[1]     = IDX_W'(len_q[0]);
	assign stride[2]     = str2_q;
	assign stride[3]     = str3_q;
	assign stride_nxt[0] = stride[1];
	assign stride_nxt[1] = stride[2];
	assign stride_nxt[2] = stride[3];
	assign stride_nxt[3] = vol_q[IDX_W-1:0];

	always_ff @(posedge clk) begin
		nd_q   <= nd_eff;
		len_q  <= len_eff;
		str2_q <= IDX_W'(len_q[0]) * IDX_W'(len_q[1]);
		str3_q <= str2_q * IDX_W'(len_q[2]);
		vol_q  <= VOL_W'(str3_q) * VOL_W'(len_q[3]);
		for (int d = 0; d < MAX_DIMS; d++) wrap_q[d] <= stride_nxt[d] - stride[d];
	end

	//------------------------------------------------------------------
	// Entry stage: volume check, load the divider.
	// div_s[0] is the entry register, div_s[k+1] the output of divide stage k.
	//------------------------------------------------------------------
	logic                    accept;
	logic [DIV_STAGES:0]     div_vld_s;
	div_pl_t                 div_s [DIV_STAGES+1];

	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_vld_s <= '0;
		end else begin
			div_vld_s <= {div_vld_s[DIV_STAGES-1:0], accept};
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			div_s[0].in_range <= ({1'b0, site_index} < vol_q);
			div_s[0].idx      <= site_index;
			div_s[0].quo      <= site_index;
			div_s[0].rem      <= '0;
			div_s[0].coord    <= '0;
		end
	end

	//------------------------------------------------------------------
	// Divide stages: STG_PER_DIM stages per dimension. At a dimension
	// boundary the finished remainder becomes a coordinate and the
	// quotient is the next dividend.
	//------------------------------------------------------------------
	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		localparam int DIM = k / STG_PER_DIM;
		div_pl_t pre;
		div_pl_t nxt;

		if ((k % STG_PER_DIM) == 0 && k > 0) begin : g_new_dim
			always_comb begin
				pre              = div_s[k];
				pre.coord[DIM-1] = div_s[k].rem;
				pre.rem          = '0;
			end
		end else begin : g_cont
			assign pre = div_s[k];
		end

		assign nxt = div_steps(pre, len_q[DIM]);

		always_ff @(posedge clk) begin
			if (div_vld_s[k]) div_s[k+1] <= nxt;
		end
	end

	//------------------------------------------------------------------
	// Exit stage: parity and wrapped neighbor adds.
	//------------------------------------------------------------------
	div_pl_t                            fin;
	logic [MAX_DIMS-1:0][COORD_W-1:0]   coord;
	logic                               par_nxt;
	logic [MAX_DIMS-1:0][IDX_W-1:0]     fwd_nxt;
	logic [MAX_DIMS-1:0][IDX_W-1:0]     bwd_nxt;
	logic                               done_q;
	logic                               in_range_q;
	logic                               parity_q;
	logic [MAX_DIMS-1:0][IDX_W-1:0]     fwd_q;
	logic [MAX_DIMS-1:0][IDX_W-1:0]     bwd_q;

	assign fin      = div_s[DIV_STAGES];
	assign coord[0] = fin.coord[0];
	assign coord[1] = fin.coord[1];
	assign coord[2] = fin.rem;
	assign coord[3] = fin.quo[COORD_W-1:0];   // in range, the last quotient is below len_3

	always_comb begin
		par_nxt = 1'b0;
		for (int d = 0; d < MAX_DIMS; d++) begin
			par_nxt = par_nxt ^ coord[d][0];
			// top coordinate wraps forward, zero coordinate wraps backward
			if (coord[d] == COORD_W'(len_q[d] - LEN_W'(1))) begin
				fwd_nxt[d] = fin.idx - wrap_q[d];
			end else begin
				fwd_nxt[d] = fin.idx + stride[d];
			end
			if (coord[d] == '0) begin
				bwd_nxt[d] = fin.idx + wrap_q[d];
			end else begin
				bwd_nxt[d] = fin.idx - stride[d];
			end
			if (!fin.in_range || DIMS_W'(d) >= nd_q) begin
				fwd_nxt[d] = '0;
				bwd_nxt[d] = '0;
			end
		end
		if (!fin.in_range) par_nxt = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= div_vld_s[DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (div_vld_s[DIV_STAGES]) begin
			in_range_q <= fin.in_range;
			parity_q   <= par_nxt;
			fwd_q      <= fwd_nxt;
			bwd_q      <= bwd_nxt;
		end
	end

	assign done      = done_q;
	assign in_range  = in_range_q;
	assign parity    = parity_q;
	assign fwd_nbr_0 = fwd_q[0];
	assign bwd_nbr_0 = bwd_q[0];
	assign fwd_nbr_1 = fwd_q[1];
	assign bwd_nbr_1 = bwd_q[1];
	assign fwd_nbr_2 = fwd_q[2];
	assign bwd_nbr_2 = bwd_q[2];
	assign fwd_nbr_3 = fwd_q[3];
	assign bwd_nbr_3 = bwd_q[3];

	//------------------------------------------------------------------
	// Assertions
	//------------------------------------------------------------------
	// every result strobe traces back to exactly one accepted command
	a_done_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result strobe without a matching accepted transaction");

	// every accepted command produces its strobe after the fixed latency
	a_accept_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("accepted transaction lost in the pipeline");

	// an out-of-range site gives zero parity and zero neighbors in dimensions 0 and 3
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !in_range) |-> (!parity && fwd_nbr_0 == '0 && bwd_nbr_0 == '0
			&& fwd_nbr_3 == '0 && bwd_nbr_3 == '0))
		else $error("out-of-range result is not all zero");

	// a register write blocks commands while geometry settles
	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite) |=> busy)
		else $error("busy not raised after a register write");

endmodule

/* test/periodic_lattice_neighbor_index_tb.sv */
// Self-checking testbench for periodic_lattice_neighbor_index: directed table, then random phases.
// Depends on plni_pkg and the periodic_lattice_neighbor_index RTL; needs nothing else.
`timescale 1ns / 1ps

module periodic_lattice_neighbor_index_tb;
	import plni_pkg::*;

	localparam int NUM_REGS    = 5;        // register indexes at or above this are unmapped
	localparam int RAND_PHASES = 9;
	localparam int PHASE_SITES = 50;       // 9 x 50 = 450 random transactions
	localparam int MAX_GAP     = 15;

	// Expected output of one transaction; fwd/bwd indexed by dimension.
	typedef struct packed {
		logic                        in_range;
		logic                        parity;
		logic [MAX_DIMS-1:0][IDX_W-1:0] fwd;
		logic [MAX_DIMS-1:0][IDX_W-1:0] bwd;
	} nbr_result_t;

	typedef enum logic {
		ROW_SITE,
		ROW_WRITE
	} row_kind_t;

	// One row of the directed table: a register write or a site index.
	typedef struct packed {
		row_kind_t          kind;
		logic [ADDR_W-1:0]  addr;
		logic [CFG_W-1:0]   data;
		logic [IDX_W-1:0]   site;
		logic               typed;     // golden holds a hand-written expectation
		nbr_result_t        golden;
	} dir_row_t;

	logic                clk;
	logic                arst_n;
	logic                psel, penable, pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [CFG_W-1:0]    pwdata;
	logic [CFG_W-1:0]    prdata;
	logic                pready;
	logic                start, busy;
	logic [IDX_W-1:0]    site_index;
	logic                done, in_range, parity;
	logic [IDX_W-1:0]    fwd_nbr_0, bwd_nbr_0, fwd_nbr_1, bwd_nbr_1;
	logic [IDX_W-1:0]    fwd_nbr_2, bwd_nbr_2, fwd_nbr_3, bwd_nbr_3;

	nbr_result_t         seen_nbrs;
	nbr_result_t         nbrs_due[$];          // expectations in acceptance order
	dir_row_t            dir_rows[$];
	int                  fail_cnt = 0;

	// Shadow copy of the block's registers, raw as written.
	logic [DIMS_W-1:0]   dims_cfg;
	logic [LEN_W-1:0]    side_cfg[MAX_DIMS];

	periodic_lattice_neighbor_index dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.start      (start),
		.busy       (busy),
		.site_index (site_index),
		.done       (done),
		.in_range   (in_range),
		.parity     (parity),
		.fwd_nbr_0  (fwd_nbr_0),
		.bwd_nbr_0  (bwd_nbr_0),
		.fwd_nbr_1  (fwd_nbr_1),
		.bwd_nbr_1  (bwd_nbr_1),
		.fwd_nbr_2  (fwd_nbr_2),
		.bwd_nbr_2  (bwd_nbr_2),
		.fwd_nbr_3  (fwd_nbr_3),
		.bwd_nbr_3  (bwd_nbr_3)
	);

	assign seen_nbrs = {in_range, parity, fwd_nbr_3, fwd_nbr_2, fwd_nbr_1, fwd_nbr_0,
			bwd_nbr_3, bwd_nbr_2, bwd_nbr_1, bwd_nbr_0};

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop, well beyond the slowest legal run.
	initial begin
		#400000;
		$display("periodic_lattice_neighbor_index test failed");
		$finish;
	end

	// ---------------------------------------------------------------- predictor

	// Effective side length of dimension d: unused dims count as 1, zero
	// reads as 1, anything past MAX_SIDE saturates.
	function automatic int unsigned eff_len(int d);
		int unsigned nd;
		int unsigned s;
		nd = dims_cfg;
		if (nd < 1) nd = 1;
		if (nd > MAX_DIMS) nd = MAX_DIMS;
		if (d >= nd) return 1;
		s = side_cfg[d];
		if (s < 1) s = 1;
		if (s > MAX_SIDE) s = MAX_SIDE;
		return s;
	endfunction

	function automatic int unsigned lattice_volume();
		int unsigned vol;
		vol = 1;
		for (int d = 0; d < MAX_DIMS; d++) vol *= eff_len(d);
		return vol;
	endfunction

	// True when dimension d lies beyond the clamped dimension count.
	function automatic bit dims_cfg_unused(int d);
		int unsigned nd;
		nd = dims_cfg;
		if (nd < 1) nd = 1;
		if (nd > MAX_DIMS) nd = MAX_DIMS;
		return d >= nd;
	endfunction

	// Mixed-radix split, parity and periodic neighbors of one site.
	function automatic nbr_result_t predict_nbrs(logic [IDX_W-1:0] idx);
		nbr_result_t r;
		int unsigned len[MAX_DIMS];
		int unsigned stride[MAX_DIMS];
		int unsigned coord[MAX_DIMS];
		int unsigned vol, rest, sum, base, up, dn;
		r = '0;
		vol = 1;
		for (int d = 0; d < MAX_DIMS; d++) begin
			len[d] = eff_len(d);
			stride[d] = vol;
			vol *= len[d];
		end
		if (idx >= vol) return r;
		rest = idx;
		sum = 0;
		for (int d = 0; d < MAX_DIMS; d++) begin
			coord[d] = rest % len[d];
			rest = rest / len[d];
			sum += coord[d];
		end
		r.in_range = 1'b1;
		r.parity = sum[0];
		// unused dims have len 1, so both neighbors would be the site itself;
		// the block reports zero for them instead
		for (int d = 0; d < MAX_DIMS; d++) begin
			if (dims_cfg_unused(d)) continue;
			base = idx - coord[d] * stride[d];
			up = (coord[d] + 1 >= len[d]) ? 0 : coord[d] + 1;
			dn = (coord[d] == 0) ? len[d] - 1 : coord[d] - 1;
			r.fwd[d] = IDX_W'(base + up * stride[d]);
			r.bwd[d] = IDX_W'(base + dn * stride[d]);
		end
		return r;
	endfunction

	function automatic nbr_result_t mk_result(logic ir, logic par,
			int unsigned f0, int unsigned b0, int unsigned f1, int unsigned b1,
			int unsigned f2, int unsigned b2, int unsigned f3, int unsigned b3);
		nbr_result_t r;
		r.in_range = ir;
		r.parity = par;
		r.fwd[0] = IDX_W'(f0);
		r.bwd[0] = IDX_W'(b0);
		r.fwd[1] = IDX_W'(f1);
		r.bwd[1] = IDX_W'(b1);
		r.fwd[2] = IDX_W'(f2);
		r.bwd[2] = IDX_W'(b2);
		r.fwd[3] = IDX_W'(f3);
		r.bwd[3] = IDX_W'(b3);
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] reg_addr(logic [2:0] idx);
		return {idx, 2'b00};
	endfunction

	// ---------------------------------------------------------------- checker

	// done is a one-cycle strobe and cannot be held off: sample it at every edge.
	always @(posedge clk) begin
		nbr_result_t want;
		if (arst_n && done) begin
			if (nbrs_due.size() == 0) begin
				$error("unexpected transaction on result side");
				fail_cnt++;
			end else begin
				want = nbrs_due.pop_front();
				if (seen_nbrs.in_range !== want.in_range) begin
					$error("in_range: expected %0d, got %0d", want.in_range, seen_nbrs.in_range);
					fail_cnt++;
				end
				if (seen_nbrs.parity !== want.parity) begin
					$error("parity: expected %0d, got %0d", want.parity, seen_nbrs.parity);
					fail_cnt++;
				end
				for (int d = 0; d < MAX_DIMS; d++) begin
					if (seen_nbrs.fwd[d] !== want.fwd[d]) begin
						$error("fwd_nbr_%0d: expected %0d, got %0d",
								d, want.fwd[d], seen_nbrs.fwd[d]);
						fail_cnt++;
					end
					if (seen_nbrs.bwd[d] !== want.bwd[d]) begin
						$error("bwd_nbr_%0d: expected %0d, got %0d",
								d, want.bwd[d], seen_nbrs.bwd[d]);
						fail_cnt++;
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------- drivers
	// The bus tasks write_reg and send_site are entered and left just after a falling edge.

	// APB write, only with nothing in flight and the block settled.
	// Leaves the bus quiet before returning so a following write never touches psel twice in a step.
	task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
		logic [2:0] ridx;
		ridx = addr[ADDR_W-1:2];
		start <= 1'b0;
		while (busy || nbrs_due.size() != 0) @(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (ridx)
			REG_DIMS_USED: dims_cfg = data[DIMS_W-1:0];
			REG_SIDE_LEN_0, REG_SIDE_LEN_1, REG_SIDE_LEN_2, REG_SIDE_LEN_3:
				side_cfg[int'(ridx) - int'(REG_SIDE_LEN_0)] = data[LEN_W-1:0];
			default: ;   // unmapped index: no effect
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	// One site transaction. start stays high on exit so back-to-back items
	// run at full rate; a gap or a register write lowers it.
	task automatic send_site(input logic [IDX_W-1:0] idx, input logic typed,
			input nbr_result_t golden, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start      <= 1'b1;
		site_index <= idx;
		do @(posedge clk); while (busy);
		nbrs_due.push_back(typed ? golden : predict_nbrs(idx));
		@(negedge clk);
	endtask

	task automatic add_write(input logic [ADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
		dir_row_t row;
		row = '0;
		row.kind = ROW_WRITE;
		row.addr = addr;
		row.data = data;
		dir_rows.push_back(row);
	endtask

	task automatic add_site(input logic [IDX_W-1:0] idx, input logic typed,
			input nbr_result_t golden);
		dir_row_t row;
		row = '0;
		row.kind = ROW_SITE;
		row.site = idx;
		row.typed = typed;
		row.golden = golden;
		dir_rows.push_back(row);
	endtask

	// Side length draw biased toward small lattices and the clamp corners.
	function automatic logic [CFG_W-1:0] draw_side();
		logic [LEN_W-1:0] s;
		case ($urandom_range(0, 9))
			0:       s = '0;                              // reads as 1
			1:       s = LEN_W'(MAX_SIDE);
			2:       s = LEN_W'($urandom_range(MAX_SIDE + 1, 127));   // saturates
			3:       s = LEN_W'(1);
			4:       s = LEN_W'(2);
			default: s = LEN_W'($urandom_range(1, 12));
		endcase
		return ($urandom() & ~CFG_W'(7'h7F)) | CFG_W'(s);
	endfunction

	// Mostly in-range sites, some at the volume edge, some anywhere in 24 bits.
	function automatic logic [IDX_W-1:0] draw_site();
		int unsigned vol;
		int unsigned pick;
		vol = lattice_volume();
		pick = $urandom_range(0, 9);
		if (pick <= 6) return IDX_W'($urandom_range(0, vol - 1));
		if (pick == 7) begin
			if (vol > {IDX_W{1'b1}}) return {IDX_W{1'b1}};
			return IDX_W'(vol - $urandom_range(0, 1));
		end
		return IDX_W'($urandom());
	endfunction

	// ---------------------------------------------------------------- stimulus

	initial begin
		dir_row_t    row;
		int          gap;
		logic [CFG_W-1:0] wdata;

		// known values on every input from time zero
		arst_n     = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		start      = 1'b0;
		site_index = '0;
		dims_cfg   = DIMS_W'(MAX_DIMS);
		for (int d = 0; d < MAX_DIMS; d++) side_cfg[d] = LEN_W'(8);

		// Directed table. Reset lattice is 8x8x8x8 (volume 4096).
		add_site(IDX_W'(0), 1'b1, mk_result(1'b1, 1'b0, 1, 7, 8, 56, 64, 448, 512, 3584));
		add_site(IDX_W'(4095), 1'b1,
				mk_result(1'b1, 1'b0, 4088, 4094, 4039, 4087, 3647, 4031, 511, 3583));
		add_site(IDX_W'(4096), 1'b1, '0);                     // first out-of-range site
		add_site({IDX_W{1'b1}}, 1'b1, '0);
		add_site(IDX_W'(1234), 1'b0, '0);
		// unmapped register index must leave the lattice alone
		add_write(reg_addr(3'(NUM_REGS)), 32'hFFFF_FFFF);
		add_site(IDX_W'(100), 1'b0, '0);
		// zero dims reads as one dim; side two makes fwd == bwd
		add_write(reg_addr(REG_DIMS_USED), 32'h0000_0000);
		add_write(reg_addr(REG_SIDE_LEN_0), 32'h0000_0002);
		add_site(IDX_W'(0), 1'b1, mk_result(1'b1, 1'b0, 1, 1, 0, 0, 0, 0, 0, 0));
		add_site(IDX_W'(1), 1'b1, mk_result(1'b1, 1'b1, 0, 0, 0, 0, 0, 0, 0, 0));
		add_site(IDX_W'(2), 1'b1, '0);
		// dims 7 clamps to 4; sides 1 x saturated x zero x 64 -> 1x64x1x64
		add_write(reg_addr(REG_DIMS_USED), 32'h0000_0007);
		add_write(reg_addr(REG_SIDE_LEN_0), 32'h0000_0001);
		add_write(reg_addr(REG_SIDE_LEN_1), 32'h0000_007F);
		add_write(reg_addr(REG_SIDE_LEN_2), 32'h0000_0000);
		add_write(reg_addr(REG_SIDE_LEN_3), 32'h0000_0040);
		add_site(IDX_W'(0), 1'b0, '0);
		add_site(IDX_W'(63), 1'b0, '0);
		add_site(IDX_W'(4095), 1'b0, '0);
		add_site(IDX_W'(4096), 1'b0, '0);
		// largest lattice, 64^4 fills all 24 bits; junk in the upper data bits
		add_write(reg_addr(REG_DIMS_USED), 32'hFFFF_FFFC);
		add_write(reg_addr(REG_SIDE_LEN_0), 32'hFFFF_FFC0);
		add_write(reg_addr(REG_SIDE_LEN_1), 32'h8000_0040);
		add_write(reg_addr(REG_SIDE_LEN_2), 32'h0000_0040);
		add_write(reg_addr(REG_SIDE_LEN_3), 32'h0000_0040);
		add_site({IDX_W{1'b1}}, 1'b0, '0);
		add_site(IDX_W'(0), 1'b0, '0);
		add_site(24'hABCDEF, 1'b0, '0);

		// reset once, released on a falling edge
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			if (row.kind == ROW_WRITE)
				write_reg(row.addr, row.data);
			else
				send_site(row.site, row.typed, row.golden, $urandom_range(0, 2));
		end

		// Random phases: new lattice each phase, written while idle.
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			if (ph == 0) begin
				// full 24-bit lattice so every index bit is in range
				write_reg(reg_addr(REG_DIMS_USED), CFG_W'(MAX_DIMS));
				for (int d = 0; d < MAX_DIMS; d++)
					write_reg(reg_addr(3'(int'(REG_SIDE_LEN_0) + d)), CFG_W'(MAX_SIDE));
			end else begin
				wdata = ($urandom() & ~CFG_W'(7)) | CFG_W'($urandom_range(0, 7));
				write_reg(reg_addr(REG_DIMS_USED), wdata);
				for (int d = 0; d < MAX_DIMS; d++)
					write_reg(reg_addr(3'(int'(REG_SIDE_LEN_0) + d)), draw_side());
				if ($urandom_range(0, 3) == 0)
					write_reg(reg_addr(3'(NUM_REGS + $urandom_range(0, 2))), $urandom());
			end
			for (int n = 0; n < PHASE_SITES; n++) begin
				// every third phase runs back to back
				gap = (ph % 3 == 0) ? 0 : $urandom_range(0, MAX_GAP);
				send_site(draw_site(), 1'b0, '0, gap);
			end
		end

		// drain: everything back, then wait out the pipeline to catch strays
		start <= 1'b0;
		while (nbrs_due.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(posedge clk);

		if (fail_cnt == 0 && nbrs_due.size() == 0)
			$display("periodic_lattice_neighbor_index test passed");
		else
			$display("periodic_lattice_neighbor_index test failed");
		$finish;
	end

endmodule
